// ===== hw/rtl/sha_pkg.sv =====
// Shared types, constants and the rotate helper of the SHA-256 stream hasher.
package sha_pkg;

  localparam int BlockBytes = 64;
  localparam int Rounds = 64;
  localparam int DigestWords = 8;
  localparam logic [7:0] PadMark = 8'h80;
  localparam logic [5:0] LengthOffset = 6'd56;

  typedef enum logic {CMD_ABSORB = 1'b0, CMD_FINISH = 1'b1} cmd_t;

  typedef struct packed {
    logic       cmd;
    logic [7:0] data_byte;
  } in_beat_t;

  typedef struct packed {
    logic [31:0] digest_word;
    logic [2:0]  word_index;
    logic        last;
  } out_beat_t;

  // Controller to datapath.
  typedef struct packed {
    logic       write_byte;
    logic [7:0] byte_value;
    logic       count_bits;
    logic       latch_length;
    logic       start_block;
    logic       round_step;
    logic       fold_hash;
    logic       reset_hash;
  } dp_cmd_t;

  // Datapath to controller.
  typedef struct packed {
    logic [5:0] fill;
    logic       last_round;
    logic [7:0] length_byte;
  } dp_status_t;

  localparam logic [31:0] InitialH [DigestWords] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  localparam logic [31:0] RoundK [Rounds] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  function automatic logic [31:0] ror32(input logic [31:0] x, input int n);
    ror32 = (x >> n) | (x << (32 - n));
  endfunction

endpackage

// ===== hw/rtl/sha_datapath.sv =====
// Block buffer, message schedule, round unit, hash words and bit counter.
module sha_datapath (
  input  logic                clk,
  input  logic                rst,
  input  sha_pkg::dp_cmd_t    cmd,
  output sha_pkg::dp_status_t status,
  output logic [31:0]         hash_out [sha_pkg::DigestWords]
);

  logic [31:0] block_mem [sha_pkg::BlockBytes / 4];
  logic [5:0]  fill;
  logic [63:0] message_bits;
  logic [63:0] length_reg;
  logic [31:0] hash_words [sha_pkg::DigestWords];
  logic [31:0] v [sha_pkg::DigestWords];
  logic [31:0] w [16];
  logic [5:0]  round;
  logic [3:0]  load_idx;
  logic        loading;
  logic [31:0] w_new;
  logic [31:0] w_cur;
  logic [31:0] sg0;
  logic [31:0] sg1;
  logic [31:0] big0;
  logic [31:0] big1;
  logic [31:0] choose;
  logic [31:0] major;
  logic [31:0] tmp1;
  logic [31:0] tmp2;

  // Schedule window: w[0] is the word of the current round.
  assign sg0  = sha_pkg::ror32(w[1], 7) ^ sha_pkg::ror32(w[1], 18) ^ (w[1] >> 3);
  assign sg1  = sha_pkg::ror32(w[14], 17) ^ sha_pkg::ror32(w[14], 19) ^ (w[14] >> 10);
  assign w_new = w[0] + sg0 + w[9] + sg1;
  assign w_cur = w[0];
  assign big1 = sha_pkg::ror32(v[4], 6) ^ sha_pkg::ror32(v[4], 11) ^ sha_pkg::ror32(v[4], 25);
  assign choose = (v[4] & v[5]) ^ (~v[4] & v[6]);
  assign tmp1 = v[7] + big1 + choose + sha_pkg::RoundK[round] + w_cur;
  assign big0 = sha_pkg::ror32(v[0], 2) ^ sha_pkg::ror32(v[0], 13) ^ sha_pkg::ror32(v[0], 22);
  assign major = (v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]);
  assign tmp2 = big0 + major;

  // The buffer holds one big-endian word per entry, written a byte lane at a
  // time and read one word a cycle.
  logic [31:0] mem_word;
  always_ff @(posedge clk) begin
    if (cmd.write_byte) begin
      block_mem[fill[5:2]][{~fill[1:0], 3'b000} +: 8] <= cmd.byte_value;
    end
    mem_word <= block_mem[load_idx];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fill <= '0;
      message_bits <= '0;
      loading <= 1'b0;
      load_idx <= '0;
      round <= '0;
      for (int i = 0; i < sha_pkg::DigestWords; i++) hash_words[i] <= sha_pkg::InitialH[i];
    end else begin
      if (cmd.write_byte) fill <= fill + 6'd1;
      if (cmd.count_bits) message_bits <= message_bits + 64'd8;
      if (cmd.latch_length) length_reg <= message_bits;
      if (cmd.start_block) begin
        // Sixteen words stream out of the buffer before the rounds begin.
        loading <= 1'b1;
        load_idx <= '0;
        round <= '0;
        for (int i = 0; i < sha_pkg::DigestWords; i++) v[i] <= hash_words[i];
      end else if (loading) begin
        load_idx <= load_idx + 4'd1;
        if (load_idx == 4'd15) loading <= 1'b0;
      end
      if (cmd.round_step) begin
        round <= round + 6'd1;
        v[7] <= v[6]; v[6] <= v[5]; v[5] <= v[4]; v[4] <= v[3] + tmp1;
        v[3] <= v[2]; v[2] <= v[1]; v[1] <= v[0]; v[0] <= tmp1 + tmp2;
      end
      if (cmd.fold_hash) begin
        for (int i = 0; i < sha_pkg::DigestWords; i++) hash_words[i] <= hash_words[i] + v[i];
      end
      if (cmd.reset_hash) begin
        for (int i = 0; i < sha_pkg::DigestWords; i++) hash_words[i] <= sha_pkg::InitialH[i];
        fill <= '0;
        message_bits <= '0;
      end
    end
  end

  // Words arrive in the cycle after their read; shift in from the top.
  logic load_valid;
  always_ff @(posedge clk) begin
    if (rst) begin
      load_valid <= 1'b0;
    end else begin
      load_valid <= loading;
    end
  end

  always_ff @(posedge clk) begin
    if (load_valid || cmd.round_step) begin
      for (int i = 0; i < 15; i++) w[i] <= w[i + 1];
      w[15] <= load_valid ? mem_word : w_new;
    end
  end

  assign status.fill = fill;
  assign status.last_round = (round == 6'd63);
  assign status.length_byte = length_reg[8 * (7 - (fill - sha_pkg::LengthOffset)) +: 8];
  assign hash_out = hash_words;

endmodule

// ===== hw/rtl/sha_controller.sv =====
// Sequencer for absorb, padding, compression and digest output.
module sha_controller (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  sha_pkg::in_beat_t   in_beat,
  output logic                out_valid,
  input  logic                out_stall,
  output logic [2:0]          out_index,
  output sha_pkg::dp_cmd_t    cmd,
  input  sha_pkg::dp_status_t status
);

  typedef enum logic [2:0] {
    S_IDLE, S_PAD, S_LENGTH, S_LOAD, S_ROUNDS, S_FOLD, S_EMIT
  } state_t;

  state_t     state;
  logic [4:0] wait_cnt;
  logic       finishing;
  logic       accept;

  assign in_stall = (state != S_IDLE);
  assign accept = in_valid && !in_stall;

  always_comb begin
    cmd = '0;
    unique case (state)
      S_IDLE: begin
        cmd.write_byte = accept;
        cmd.byte_value = (in_beat.cmd == sha_pkg::CMD_FINISH) ? sha_pkg::PadMark
                                                             : in_beat.data_byte;
        cmd.count_bits = accept && (in_beat.cmd == sha_pkg::CMD_ABSORB);
        cmd.latch_length = accept && (in_beat.cmd == sha_pkg::CMD_FINISH);
        cmd.start_block = accept && (status.fill == 6'd63);
      end
      S_PAD: begin
        cmd.write_byte = (status.fill != 6'd0) || !finishing;
        cmd.byte_value = 8'd0;
        cmd.start_block = (status.fill == 6'd63);
      end
      S_LENGTH: begin
        cmd.write_byte = 1'b1;
        cmd.byte_value = status.length_byte;
        cmd.start_block = (status.fill == 6'd63);
      end
      S_LOAD: ;
      S_ROUNDS: cmd.round_step = 1'b1;
      S_FOLD: cmd.fold_hash = 1'b1;
      S_EMIT: cmd.reset_hash = !out_stall && (out_index == 3'd7);
      default: ;
    endcase
  end

  // finishing marks the length block, after which the digest goes out.
  logic pad_spill;
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      finishing <= 1'b0;
      pad_spill <= 1'b0;
      wait_cnt <= '0;
      out_valid <= 1'b0;
      out_index <= '0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            if (in_beat.cmd == sha_pkg::CMD_FINISH) begin
              pad_spill <= 1'b1;
              if (status.fill == 6'd63) begin
                state <= S_LOAD;
                wait_cnt <= '0;
              end else if (status.fill == 6'd55) begin
                state <= S_LENGTH;
              end else begin
                state <= S_PAD;
              end
            end else if (status.fill == 6'd63) begin
              state <= S_LOAD;
              wait_cnt <= '0;
            end
          end
        end
        S_PAD: begin
          if (status.fill == 6'd63) begin
            state <= S_LOAD;
            wait_cnt <= '0;
          end else if (status.fill == 6'd55) begin
            state <= S_LENGTH;
          end
        end
        S_LENGTH: begin
          if (status.fill == 6'd63) begin
            finishing <= 1'b1;
            state <= S_LOAD;
            wait_cnt <= '0;
          end
        end
        S_LOAD: begin
          // Sixteen reads, then the registered read data of the last word.
          wait_cnt <= wait_cnt + 5'd1;
          if (wait_cnt == 5'd16) state <= S_ROUNDS;
        end
        S_ROUNDS: if (status.last_round) state <= S_FOLD;
        S_FOLD: begin
          if (finishing) begin
            state <= S_EMIT;
            out_valid <= 1'b1;
            out_index <= '0;
          end else if (pad_spill) begin
            state <= (status.fill == 6'd56) ? S_LENGTH : S_PAD;
          end else begin
            state <= S_IDLE;
          end
        end
        S_EMIT: begin
          if (!out_stall) begin
            out_index <= out_index + 3'd1;
            if (out_index == 3'd7) begin
              out_valid <= 1'b0;
              finishing <= 1'b0;
              pad_spill <= 1'b0;
              state <= S_IDLE;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

// ===== hw/rtl/sha256_stream_hasher.sv =====
// Top level of the SHA-256 stream hasher.
// One beat carries one message byte (absorb) or a finish command. An absorb
// beat is taken while the hasher is idle; every 64th byte starts a block
// compression (16 schedule loads, the registered read, 64 rounds, one fold)
// on the single round unit, during which input is stalled. A finish beat
// pads the message a byte a cycle, held during block compressions, compresses
// one or two more blocks and then emits the eight digest words, word 0 first,
// the last one marked; the hasher then starts a fresh message.
module sha256_stream_hasher (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  sha_pkg::in_beat_t   in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output sha_pkg::out_beat_t  out_data
);

  sha_pkg::dp_cmd_t    cmd;
  sha_pkg::dp_status_t status;
  logic [31:0]         hash_out [sha_pkg::DigestWords];
  logic [2:0]          out_index;

  sha_controller u_ctrl (
    .clk, .rst, .in_valid, .in_stall, .in_beat(in_data),
    .out_valid, .out_stall, .out_index, .cmd, .status
  );

  sha_datapath u_dp (.clk, .rst, .cmd, .status, .hash_out);

  assign out_data.digest_word = hash_out[out_index];
  assign out_data.word_index = out_index;
  assign out_data.last = (out_index == 3'd7);

endmodule

// ===== hw/rtl/sha_checker.sv =====
// Port-level checks of the SHA-256 stream hasher, bound to the top level.
module sha_checker (
  input logic               clk,
  input logic               rst,
  input logic               in_stall,
  input logic               out_valid,
  input logic               out_stall,
  input sha_pkg::out_beat_t out_data
);

  a_no_input_while_output: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> in_stall) else $error("input taken during digest output");

  a_last_marks_seven: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (out_data.last == (out_data.word_index == 3'd7)))
    else $error("last flag out of place");

  a_index_steps: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_stall && !out_data.last) |=>
      (out_valid && out_data.word_index == $past(out_data.word_index) + 3'd1))
    else $error("digest word skipped");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> (out_valid && $stable(out_data)))
    else $error("stalled beat changed");

endmodule

bind sha256_stream_hasher sha_checker u_chk (
  .clk, .rst, .in_stall, .out_valid, .out_stall, .out_data
);
